// ----- hw/rtl/module_isolation_arbiter_unit_macros.svh -----
// Assertion macros used by the arbiter core RTL.
`ifndef MODULE_ISOLATION_ARBITER_UNIT_MACROS_SVH
`define MODULE_ISOLATION_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MIAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MIAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/miau_pkg.sv -----
package miau_pkg;

    localparam int SLOTS    = 8;
    localparam int SLOT_W   = 3;
    localparam int TICK_W   = 9;
    localparam int FAIL_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [FAIL_W-1:0] LIMIT_RESET = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT_TICKS = 2'd0,
        CFG_FAILURE_LIMIT = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_GRANT       = 3'd1,
        EV_RELEASE     = 3'd2,
        EV_TIMEOUT     = 3'd3,
        EV_POWER_CYCLE = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0]        timeout_ticks;
        logic [FAIL_W-1:0] failure_limit;
    } t_cfg;

    typedef struct packed {
        t_event            event_code;
        logic [SLOT_W-1:0] event_module;
        logic [SLOTS-1:0]  bus_enable_mask;
        logic              holder_active;
        logic [SLOT_W-1:0] holder_module;
    } t_result;

endpackage

// ----- hw/rtl/miau_scan.sv -----
module miau_scan #(
    parameter int SCAN_N = 8
) (
    input  logic [miau_pkg::SLOTS-1:0]  i_request,
    input  logic                        i_excl_valid,
    input  logic [miau_pkg::SLOT_W-1:0] i_excl_slot,
    output logic                        o_found,
    output logic [miau_pkg::SLOT_W-1:0] o_slot
);

    logic [miau_pkg::SLOTS-1:0] cand;

    always_comb begin
        for (int i = 0; i < miau_pkg::SLOTS; i++) begin
            cand[i] = i_request[i] && (i < SCAN_N)
                && !(i_excl_valid && (i_excl_slot == miau_pkg::SLOT_W'(i)));
        end
    end

    always_comb begin
        o_found = 1'b0;
        o_slot  = '0;
        for (int i = miau_pkg::SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_found = 1'b1;
                o_slot  = miau_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// ----- hw/rtl/miau_core.sv -----
`include "module_isolation_arbiter_unit_macros.svh"

module miau_core #(
    parameter int SCAN_N = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [miau_pkg::SLOTS-1:0] i_request,
    input  logic [miau_pkg::SLOTS-1:0] i_enabled,
    input  miau_pkg::t_cfg             i_cfg,
    output miau_pkg::t_result          o_result
);

    logic                          r_holding, n_holding;
    logic [miau_pkg::SLOT_W-1:0]   r_holder, n_holder;
    logic                          r_last_valid, n_last_valid;
    logic [miau_pkg::SLOT_W-1:0]   r_last_slot, n_last_slot;
    logic [miau_pkg::TICK_W-1:0]   r_ticks, n_ticks;
    logic [miau_pkg::SLOTS-1:0]    r_bus_mask, n_bus_mask;
    logic [miau_pkg::FAIL_W-1:0]   r_fail [miau_pkg::SLOTS];
    logic [miau_pkg::FAIL_W-1:0]   n_fail;
    logic                          fail_we;
    miau_pkg::t_result             r_result, n_result;

    logic                          scan_found;
    logic [miau_pkg::SLOT_W-1:0]   scan_slot;
    logic [miau_pkg::FAIL_W-1:0]   fail_cur;
    logic [miau_pkg::FAIL_W-1:0]   fail_inc;

    miau_scan #(
        .SCAN_N (SCAN_N)
    ) u_scan (
        .i_request    (i_request),
        .i_excl_valid (r_last_valid),
        .i_excl_slot  (r_last_slot),
        .o_found      (scan_found),
        .o_slot       (scan_slot)
    );

    assign fail_cur = r_fail[r_holder];
    assign fail_inc = (fail_cur < miau_pkg::FAIL_MAX) ? fail_cur + 1'b1 : fail_cur;

    always_comb begin
        miau_pkg::t_event ev;
        logic [miau_pkg::SLOT_W-1:0] ev_mod;
        n_holding    = r_holding;
        n_holder     = r_holder;
        n_last_valid = r_last_valid;
        n_last_slot  = r_last_slot;
        n_ticks      = r_ticks;
        n_bus_mask   = r_bus_mask;
        n_fail       = fail_cur;
        fail_we      = 1'b0;
        ev           = miau_pkg::EV_NONE;
        ev_mod       = '0;
        if (!r_holding) begin
            if (scan_found) begin
                n_holding    = 1'b1;
                n_holder     = scan_slot;
                n_last_valid = 1'b1;
                n_last_slot  = scan_slot;
                n_ticks      = '0;
                n_bus_mask   = miau_pkg::SLOTS'(1) << scan_slot;
                ev           = miau_pkg::EV_GRANT;
                ev_mod       = scan_slot;
            end else begin
                n_last_valid = 1'b0;
            end
        end else if (!i_request[r_holder]) begin
            n_fail     = '0;
            fail_we    = 1'b1;
            n_holding  = 1'b0;
            n_bus_mask = i_enabled;
            ev         = miau_pkg::EV_RELEASE;
            ev_mod     = r_holder;
        end else if (r_ticks > {1'b0, i_cfg.timeout_ticks}) begin
            fail_we = 1'b1;
            if (fail_inc > i_cfg.failure_limit) begin
                n_fail = '0;
                ev     = miau_pkg::EV_POWER_CYCLE;
            end else begin
                n_fail = fail_inc;
                ev     = miau_pkg::EV_TIMEOUT;
            end
            ev_mod     = r_holder;
            n_holding  = 1'b0;
            n_bus_mask = i_enabled;
        end else begin
            n_ticks = r_ticks + 1'b1;
        end
        n_result.event_code      = ev;
        n_result.event_module    = ev_mod;
        n_result.bus_enable_mask = n_bus_mask;
        n_result.holder_active   = n_holding;
        n_result.holder_module   = n_holding ? n_holder : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding    <= 1'b0;
            r_holder     <= '0;
            r_last_valid <= 1'b0;
            r_last_slot  <= '0;
            r_ticks      <= '0;
            r_bus_mask   <= '1;
            for (int i = 0; i < miau_pkg::SLOTS; i++) begin
                r_fail[i] <= '0;
            end
        end else if (i_advance) begin
            r_holding    <= n_holding;
            r_holder     <= n_holder;
            r_last_valid <= n_last_valid;
            r_last_slot  <= n_last_slot;
            r_ticks      <= n_ticks;
            r_bus_mask   <= n_bus_mask;
            if (fail_we) begin
                r_fail[r_holder] <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    `MIAU_ASSERT_NOW(a_bus_onehot, r_holding, r_bus_mask == (miau_pkg::SLOTS'(1) << r_holder), "bus mask does not match holder")
    `MIAU_ASSERT_NEXT(a_grant_holds, i_advance && !r_holding && scan_found, r_holding && r_last_valid && (r_last_slot == r_holder), "grant did not take hold")
    `MIAU_ASSERT_NEXT(a_release, i_advance && r_holding && !i_request[r_holder], !r_holding && (r_result.event_code == miau_pkg::EV_RELEASE), "release not taken")
    `MIAU_ASSERT_NEXT(a_result_state, i_advance, (r_result.holder_active == r_holding) && (r_result.bus_enable_mask == r_bus_mask), "result does not reflect state")

endmodule

// ----- hw/rtl/module_isolation_arbiter_unit.sv -----
// A word accepted on the input is held in the input register; its result is registered when it advances.
// Throughput: one word per cycle while the output is not stalled; the grant scan and the state update happen together.
// A stalled output holds the input off only once the input register is also full.
// Reset (i_rst_n low, synchronous) clears all holder state and failure counts,
// sets the bus enable mask to all ones and loads timeout 10 and failure limit 4.
// No word and no register write is taken while reset is low.
module module_isolation_arbiter_unit #(
    parameter int MODULE_COUNT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_request_lines,
    input  logic [7:0]                          i_enabled_mask,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_event_code,
    output logic [2:0]                          o_event_module,
    output logic [7:0]                          o_bus_enable_mask,
    output logic                                o_holder_active,
    output logic [2:0]                          o_holder_module,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [miau_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [miau_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SCAN_N = (MODULE_COUNT < miau_pkg::SLOTS) ? MODULE_COUNT : miau_pkg::SLOTS;

    logic              r_in_valid;
    logic [7:0]        r_req;
    logic [7:0]        r_en;
    logic              r_out_valid;
    miau_pkg::t_cfg    r_cfg;
    miau_pkg::t_result result;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = i_rst_n && (!r_in_valid || advance);
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_request_lines;
            r_en  <= i_enabled_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= miau_pkg::TIMEOUT_RESET;
            r_cfg.failure_limit <= miau_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                miau_pkg::CFG_TIMEOUT_TICKS: begin
                    r_cfg.timeout_ticks <= i_cfg_data;
                end
                miau_pkg::CFG_FAILURE_LIMIT: begin
                    r_cfg.failure_limit <= i_cfg_data[miau_pkg::FAIL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    miau_core #(
        .SCAN_N (SCAN_N)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_request (r_req),
        .i_enabled (r_en),
        .i_cfg     (r_cfg),
        .o_result  (result)
    );

    assign o_out_valid       = r_out_valid;
    assign o_event_code      = result.event_code;
    assign o_event_module    = result.event_module;
    assign o_bus_enable_mask = result.bus_enable_mask;
    assign o_holder_active   = result.holder_active;
    assign o_holder_module   = result.holder_module;

endmodule
